// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    `ASSERT_CLK(label, clk, rstn, !(cond))

`endif

// ===== hw/rtl/prd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_pkg
// Types and constants for the polled reply deframer.
// ----------------------------------------------------------------------------
package prd_pkg;

    localparam int MAX_PORTS    = 64;
    localparam int BYTES_LEFT_W = $clog2(MAX_PORTS + 1);
    localparam int PORT_INDEX_W = 6;
    localparam int TICKS_W      = 16;

    localparam logic [TICKS_W-1:0] MAX_TRIES_RESET = 16'd100;

    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_DLE = 8'h10;
    localparam logic [7:0] CH_A   = 8'h41;
    localparam logic [7:0] CH_R   = 8'h52;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_DONE    = 3'd1,
        ST_TIMEOUT = 3'd2,
        ST_BADADDR = 3'd3,
        ST_NOTREAD = 3'd4,
        ST_UNESC   = 3'd5,
        ST_NOETX   = 3'd6
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [6:0] node_address;
        logic [6:0] port_count;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic                    valid;
        logic [7:0]              port_value;
        logic [PORT_INDEX_W-1:0] port_index;
        status_t                 status;
        logic                    last;
    } result_t;

endpackage

// ===== hw/rtl/polled_reply_deframer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polled_reply_deframer_unit
// Deframes a polled node's reply into indexed port bytes and a status.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock while not stalled: a start, a received
// byte or a timer tick. Each transaction passes through an input register, a
// single pass of frame logic that updates the frame state, and an output
// register, from which a result is presented on m_tvalid. Throughput is set
// by that one state update per transaction. The output register decouples the
// two sides: a new transaction is still taken while a result waits, and
// s_tready drops only when both registers are full and m_tready is low. No
// clearing pass follows reset. Errors and the closing ETX carry m_tlast; the
// consumer drops the partial frame on any non-data, non-done status.
`include "assert_macros.svh"

module polled_reply_deframer_unit (
    input  logic                         aclk,
    input  logic                         aresetn,

    // configuration: max_tries
    input  logic                         cfg_wr_en,
    input  logic [prd_pkg::TICKS_W-1:0]  cfg_wr_data,

    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,   // node_address, port_count, rx_byte, pad
    input  logic [1:0]                   s_tuser,   // operation

    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [15:0]                  m_tdata,   // port_value, port_index, pad
    output logic [2:0]                   m_tuser,   // status
    output logic                         m_tlast
);

    logic [prd_pkg::TICKS_W-1:0] max_tries_reg;

    logic                        in_valid_reg, in_valid_next;
    prd_pkg::item_t              in_item_reg;
    logic                        s_fire;
    logic                        advance;
    logic                        in_stall;

    prd_pkg::result_t            res;
    logic                        m_tvalid_reg, m_tvalid_next;
    prd_pkg::result_t            out_reg;

    // a pass runs when the input stage holds a transaction and the output slot is free
    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;
    assign in_stall = in_valid_reg && m_tvalid_reg && !m_tready;

    assign in_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign m_tvalid_next = advance ? res.valid : (m_tready ? 1'b0 : m_tvalid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_tries_reg <= prd_pkg::MAX_TRIES_RESET;
            in_valid_reg  <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) max_tries_reg <= cfg_wr_data;
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.op           <= prd_pkg::op_t'(s_tuser);
            in_item_reg.node_address <= s_tdata[6:0];
            in_item_reg.port_count   <= s_tdata[13:7];
            in_item_reg.rx_byte      <= s_tdata[21:14];
        end
        if (advance) out_reg <= res;
    end

    prd_frame_fsm u_fsm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .max_tries (max_tries_reg),
        .fire      (advance),
        .item      (in_item_reg),
        .res       (res)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_reg.port_index, out_reg.port_value};
    assign m_tuser  = out_reg.status;
    assign m_tlast  = out_reg.last;

    `ASSERT_NEVER(a_stall_only_full, aclk, aresetn, !s_tready && !in_stall)
    `ASSERT_CLK(a_result_from_pass, aclk, aresetn, $rose(m_tvalid_reg) |-> $past(advance))

endmodule

// ===== hw/rtl/prd_frame_fsm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prd_frame_fsm
// Frame state and single-pass decision for one transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prd_frame_fsm (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [prd_pkg::TICKS_W-1:0]    max_tries,
    input  logic                           fire,
    input  prd_pkg::item_t                 item,
    output prd_pkg::result_t               res
);

    typedef enum logic [6:0] {
        PH_IDLE = 7'b0000001,
        PH_HUNT = 7'b0000010,
        PH_ADDR = 7'b0000100,
        PH_TYPE = 7'b0001000,
        PH_DATA = 7'b0010000,
        PH_ESC  = 7'b0100000,
        PH_ETX  = 7'b1000000
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [6:0]                          want_address_reg, want_address_next;
    logic [prd_pkg::BYTES_LEFT_W-1:0]    bytes_left_reg, bytes_left_next;
    logic [prd_pkg::PORT_INDEX_W-1:0]    next_index_reg, next_index_next;
    logic [prd_pkg::TICKS_W-1:0]         idle_ticks_reg, idle_ticks_next;

    logic                                fail_hit;
    prd_pkg::status_t                    fail_status;
    logic [prd_pkg::TICKS_W-1:0]         ticks_inc;
    logic [7:0]                          addr_char;
    logic [prd_pkg::BYTES_LEFT_W-1:0]    bytes_dec;
    logic                                is_start;
    logic                                res_end;

    assign ticks_inc = (idle_ticks_reg == {prd_pkg::TICKS_W{1'b1}})
                     ? idle_ticks_reg : idle_ticks_reg + 1'b1;
    assign addr_char = {1'b0, want_address_reg} + prd_pkg::CH_A;
    assign bytes_dec = (bytes_left_reg != '0) ? bytes_left_reg - 1'b1 : bytes_left_reg;
    assign is_start  = fire && (item.op == prd_pkg::OP_START);
    assign res_end   = (res.status != prd_pkg::ST_DATA);

    always_comb begin
        phase_next        = phase_reg;
        want_address_next = want_address_reg;
        bytes_left_next   = bytes_left_reg;
        next_index_next   = next_index_reg;
        idle_ticks_next   = idle_ticks_reg;
        fail_hit          = 1'b0;
        fail_status       = prd_pkg::ST_DATA;
        res               = '0;
        res.status        = prd_pkg::ST_DATA;

        if (fire) begin
            unique case (item.op)
                prd_pkg::OP_START: begin
                    want_address_next = item.node_address;
                    if (32'(item.port_count) > prd_pkg::MAX_PORTS) begin
                        bytes_left_next = prd_pkg::BYTES_LEFT_W'(prd_pkg::MAX_PORTS);
                    end else begin
                        bytes_left_next = prd_pkg::BYTES_LEFT_W'(item.port_count);
                    end
                    next_index_next = '0;
                    idle_ticks_next = '0;
                    phase_next      = PH_HUNT;
                end
                prd_pkg::OP_TICK: begin
                    if (phase_reg != PH_IDLE) begin
                        idle_ticks_next = ticks_inc;
                        if (ticks_inc >= max_tries) begin
                            fail_hit    = 1'b1;
                            fail_status = prd_pkg::ST_TIMEOUT;
                        end
                    end
                end
                prd_pkg::OP_BYTE: begin
                    if (phase_reg != PH_IDLE) begin
                        idle_ticks_next = '0;
                        unique case (phase_reg)
                            PH_HUNT: begin
                                if (item.rx_byte == prd_pkg::CH_STX) phase_next = PH_ADDR;
                            end
                            PH_ADDR: begin
                                if (item.rx_byte != addr_char) begin
                                    fail_hit    = 1'b1;
                                    fail_status = prd_pkg::ST_BADADDR;
                                end else begin
                                    phase_next = PH_TYPE;
                                end
                            end
                            PH_TYPE: begin
                                if (item.rx_byte != prd_pkg::CH_R) begin
                                    fail_hit    = 1'b1;
                                    fail_status = prd_pkg::ST_NOTREAD;
                                end else begin
                                    phase_next = (bytes_left_reg == '0) ? PH_ETX : PH_DATA;
                                end
                            end
                            PH_DATA, PH_ESC: begin
                                if (phase_reg == PH_DATA &&
                                    (item.rx_byte == prd_pkg::CH_STX ||
                                     item.rx_byte == prd_pkg::CH_ETX)) begin
                                    fail_hit    = 1'b1;
                                    fail_status = prd_pkg::ST_UNESC;
                                end else if (phase_reg == PH_DATA &&
                                             item.rx_byte == prd_pkg::CH_DLE) begin
                                    phase_next = PH_ESC;
                                end else begin
                                    // data byte, escaped or plain
                                    res.valid       = 1'b1;
                                    res.port_value  = item.rx_byte;
                                    res.port_index  = next_index_reg;
                                    next_index_next = next_index_reg + 1'b1;
                                    bytes_left_next = bytes_dec;
                                    phase_next      = (bytes_dec == '0) ? PH_ETX : PH_DATA;
                                end
                            end
                            PH_ETX: begin
                                if (item.rx_byte != prd_pkg::CH_ETX) begin
                                    fail_hit    = 1'b1;
                                    fail_status = prd_pkg::ST_NOETX;
                                end else begin
                                    phase_next      = PH_IDLE;
                                    bytes_left_next = '0;
                                    next_index_next = '0;
                                    res.valid       = 1'b1;
                                    res.status      = prd_pkg::ST_DONE;
                                    res.last        = 1'b1;
                                end
                            end
                            default: begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase

            if (fail_hit) begin
                phase_next      = PH_IDLE;
                bytes_left_next = '0;
                next_index_next = '0;
                idle_ticks_next = '0;
                res             = '0;
                res.valid       = 1'b1;
                res.status      = fail_status;
                res.last        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            want_address_reg <= '0;
            bytes_left_reg   <= '0;
            next_index_reg   <= '0;
            idle_ticks_reg   <= '0;
        end else begin
            phase_reg        <= phase_next;
            want_address_reg <= want_address_next;
            bytes_left_reg   <= bytes_left_next;
            next_index_reg   <= next_index_next;
            idle_ticks_reg   <= idle_ticks_next;
        end
    end

    `ASSERT_CLK(a_phase_onehot, aclk, aresetn, $onehot(phase_reg))
    `ASSERT_CLK(a_start_arms, aclk, aresetn, is_start |=> (phase_reg == PH_HUNT))
    `ASSERT_CLK(a_last_on_end, aclk, aresetn, res.valid |-> (res.last == res_end))

endmodule
